>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/bplb_pkg.sv
// ---------------------------------------------------------------------------
// bplb_pkg
// Command codes, constants and color reordering helpers of the plane buffer.
// ---------------------------------------------------------------------------
package bplb_pkg;

  typedef logic [2:0]  cmd_t;
  typedef logic [23:0] rgb_t;

  localparam cmd_t CMD_SET  = 3'd0;
  localparam cmd_t CMD_GET  = 3'd1;
  localparam cmd_t CMD_OR   = 3'd2;
  localparam cmd_t CMD_XOR  = 3'd3;
  localparam cmd_t CMD_DIM  = 3'd4;
  localparam cmd_t CMD_FILL = 3'd5;

  // Plane bytes per pixel and top bit of a component.
  localparam int          PLANES   = 24;
  localparam logic [7:0]  TOP_BIT  = 8'h80;
  localparam logic [7:0]  FULL_PCT = 8'd100;
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 25600.
  localparam logic [15:0] RECIP_100   = 16'd41944;
  localparam int          RECIP_SHIFT = 22;

  function automatic rgb_t rgb_to_grb(input rgb_t rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

  function automatic rgb_t grb_to_rgb(input rgb_t grb);
    return {grb[15:8], grb[23:16], grb[7:0]};
  endfunction

endpackage

>>> rtl/core/bitplane_led_pixel_buffer.sv
// ---------------------------------------------------------------------------
// bitplane_led_pixel_buffer
// Bit-transposed frame buffer for parallel LED strips with pixel commands.
// ---------------------------------------------------------------------------
// Commands are taken one at a time: in_ready stays low from an input beat
// until its result beat, and the result beat and ready return on the same
// edge. Sweeps move one plane byte per cycle through the single store port
// pair; dim also uses the shared multiplier. After reset a clearing sweep
// writes zero to all 24*LEDS_PER_LANE plane bytes before ready.
// ---------------------------------------------------------------------------
module bitplane_led_pixel_buffer #(
  parameter int LANES         = 8,
  parameter int LEDS_PER_LANE = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_lane,
  input  logic [7:0]  in_position,
  input  logic [23:0] in_color,
  input  logic [7:0]  in_percent,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [23:0] out_color_result
);

  `include "assert_macros.svh"

  // Store geometry. DEPTH is a multiple of three, so never a power of two,
  // and an address one past the end still fits in ADDR_W bits.
  localparam int DEPTH  = LEDS_PER_LANE * bplb_pkg::PLANES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Plane bits that belong to existing lanes; fill-all keeps the others.
  localparam logic [7:0] LANE_MASK = 8'((1 << LANES) - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DIM,
    S_SWEEP,
    S_DONE
  } state_t;

  // Control
  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ADDR_W-1:0]   addr_r;       // read address of the current sweep
  logic [ADDR_W-1:0]   addr_q_r;     // registered copy of addr_r, the last read address
  logic [ADDR_W-1:0]   base_r;       // first plane byte of the pixel
  logic                full_r;       // sweep covers the whole store
  logic                report_r;     // sweep ends with a result beat
  logic [2:0]          step_r;       // dim sequencer step
  // Operands and pixel values
  bplb_pkg::cmd_t      cmd_r;
  logic [2:0]          lane_r;
  logic [7:0]          mask_r;
  logic [6:0]          keep_r;       // 100 - saturated percent
  bplb_pkg::rgb_t      op_grb_r;     // operand in plane order
  bplb_pkg::rgb_t      grb_r;        // pixel read back, plane order
  bplb_pkg::rgb_t      new_r;        // value to store, rotated while written
  logic                res_status_r;
  logic [14:0]         prod_r;
  // Result register
  logic                out_valid_r;
  logic                out_status_r;
  bplb_pkg::rgb_t      out_color_r;

  // Plane store
  logic [7:0]          mem [DEPTH];
  logic [7:0]          rd_data_r;
  logic                rd_en;
  logic                wr_en;
  logic [7:0]          wr_data;

  // Shared multiplier
  logic [15:0]         mul_a;
  logic [15:0]         mul_b;
  logic [31:0]         mul_p;
  logic [7:0]          dim_in;
  logic [1:0]          comp;

  // Accept-side decode
  logic                acc;
  logic                lane_err;
  logic                pos_err;
  logic [7:0]          pct_sat;
  logic [ADDR_W-1:0]   base_nxt;
  logic [CNT_W-1:0]    cnt_last;

  assign in_ready         = (state_r == S_IDLE);
  assign acc              = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_color_result = out_color_r;

  assign lane_err = {1'b0, in_lane} >= 4'(LANES);
  assign pos_err  = {1'b0, in_position} >= 9'(LEDS_PER_LANE);
  assign pct_sat  = (in_percent > bplb_pkg::FULL_PCT) ? bplb_pkg::FULL_PCT : in_percent;
  // position * 24 as two shifted copies
  assign base_nxt = ADDR_W'({in_position, 4'b0000}) + ADDR_W'({in_position, 3'b000});

  assign cnt_last = full_r ? CNT_W'(DEPTH) : CNT_W'(bplb_pkg::PLANES);

  // Read one plane byte per cycle in S_READ and S_SWEEP; in S_SWEEP write back
  // the byte read in the previous cycle with the lane bits replaced by the current plane bit.
  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    if (state_r == S_READ) begin
      rd_en = cnt_r < CNT_W'(bplb_pkg::PLANES);
    end else if (state_r == S_SWEEP) begin
      rd_en = cnt_r < cnt_last;
      wr_en = cnt_r != '0;
    end
  end

  assign wr_data = (rd_data_r & ~mask_r) | ({8{new_r[23]}} & mask_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_q_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // Dim: even steps form component * keep, odd steps scale by 1/100.
  assign comp = step_r[2:1];

  always_comb begin
    case (comp)
      2'd0:    dim_in = grb_r[23:16];
      2'd1:    dim_in = grb_r[15:8];
      default: dim_in = grb_r[7:0];
    endcase
  end

  assign mul_a = step_r[0] ? {1'b0, prod_r} : {8'h00, dim_in};
  assign mul_b = step_r[0] ? bplb_pkg::RECIP_100 : {9'h000, keep_r};
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Start the clearing sweep: all lanes, plane bit zero.
      state_r     <= S_SWEEP;
      cnt_r       <= '0;
      addr_r      <= '0;
      full_r      <= 1'b1;
      report_r    <= 1'b0;
      new_r       <= '0;
      mask_r      <= 8'hFF;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      addr_q_r <= addr_r;

      // Drop the result beat once taken.
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (acc) begin
            cmd_r        <= in_cmd;
            lane_r       <= in_lane;
            base_r       <= base_nxt;
            mask_r       <= 8'(1 << in_lane);
            keep_r       <= 7'(bplb_pkg::FULL_PCT - pct_sat);
            op_grb_r     <= bplb_pkg::rgb_to_grb(in_color);
            res_status_r <= 1'b0;
            cnt_r        <= '0;
            full_r       <= 1'b0;
            report_r     <= 1'b1;
            if (in_cmd == bplb_pkg::CMD_FILL) begin
              new_r   <= bplb_pkg::rgb_to_grb(in_color);
              mask_r  <= LANE_MASK;
              full_r  <= 1'b1;
              addr_r  <= '0;
              state_r <= S_SWEEP;
            end else if (lane_err || pos_err) begin
              new_r        <= '0;
              res_status_r <= 1'b1;
              state_r      <= S_DONE;
            end else if (in_cmd == bplb_pkg::CMD_SET) begin
              new_r   <= bplb_pkg::rgb_to_grb(in_color);
              addr_r  <= base_nxt;
              state_r <= S_SWEEP;
            end else begin
              addr_r  <= base_nxt;
              state_r <= S_READ;
            end
          end
        end

        // Gather the pixel one plane byte at a time, MSB of green first.
        S_READ: begin
          if (rd_en) begin
            addr_r <= addr_r + ADDR_W'(1);
          end
          if (cnt_r != '0) begin
            grb_r <= {grb_r[22:0], rd_data_r[lane_r]};
          end
          if (cnt_r == CNT_W'(bplb_pkg::PLANES)) begin
            state_r <= S_CALC;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end

        S_CALC: begin
          cnt_r  <= '0;
          addr_r <= base_r;
          step_r <= '0;
          case (cmd_r)
            bplb_pkg::CMD_OR: begin
              new_r   <= grb_r | op_grb_r;
              state_r <= S_SWEEP;
            end
            bplb_pkg::CMD_XOR: begin
              new_r   <= grb_r ^ op_grb_r;
              state_r <= S_SWEEP;
            end
            bplb_pkg::CMD_DIM: begin
              state_r <= S_DIM;
            end
            default: begin
              // get and unused codes: read only
              new_r   <= grb_r;
              state_r <= S_DONE;
            end
          endcase
        end

        S_DIM: begin
          if (!step_r[0]) begin
            prod_r <= mul_p[14:0];
          end else begin
            case (comp)
              2'd0:    new_r[23:16] <= mul_p[bplb_pkg::RECIP_SHIFT +: 8];
              2'd1:    new_r[15:8]  <= mul_p[bplb_pkg::RECIP_SHIFT +: 8];
              default: new_r[7:0]   <= mul_p[bplb_pkg::RECIP_SHIFT +: 8];
            endcase
          end
          if (step_r == 3'd5) begin
            state_r <= S_SWEEP;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end

        // Read-modify-write pass. new_r rotates once per byte and is back
        // in place after a multiple of 24 bytes.
        S_SWEEP: begin
          if (rd_en) begin
            addr_r <= addr_r + ADDR_W'(1);
          end
          if (wr_en) begin
            new_r <= {new_r[22:0], new_r[23]};
          end
          if (cnt_r == cnt_last) begin
            state_r <= report_r ? S_DONE : S_IDLE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end

        // Hold until the result register is free.
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_color_r  <= bplb_pkg::grb_to_rgb(new_r);
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_wr_in_range, clk, rst_n, wr_en |-> (int'(addr_q_r) < DEPTH))
  `ASSERT_NEVER(a_rw_same_addr, clk, rst_n, rd_en && wr_en && (addr_r == addr_q_r))
  `ASSERT_PROP(a_read_addr, clk, rst_n, (state_r == S_READ) |-> (addr_r == base_r + ADDR_W'(cnt_r)))
  `ASSERT_PROP(a_dim_cmd, clk, rst_n, (state_r == S_DIM) |-> (cmd_r == bplb_pkg::CMD_DIM))

endmodule
